// ----- rtl/core/hcmc_pkg.sv -----
package hcmc_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int LIM_W   = 10;
  localparam int CMP_W   = (COL_W > LIM_W) ? COL_W : LIM_W;
  localparam int CH_W    = 8;
  localparam int SUM_W   = 30;
  localparam int CNT_W   = 21;
  localparam int CEN_W   = 10;
  localparam int STEP_W  = $clog2(SUM_W);
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 10;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(MAX_WIDTH - 1);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(MAX_HEIGHT - 1);

  localparam logic [CH_W-1:0] MASK_ON  = 8'd255;
  localparam logic [CH_W-1:0] MASK_OFF = 8'd0;

  localparam logic KIND_MASK     = 1'b0;
  localparam logic KIND_CENTROID = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HUE_MIN  = 3'd0,
    REG_HUE_MAX  = 3'd1,
    REG_SAT_MIN  = 3'd2,
    REG_SAT_MAX  = 3'd3,
    REG_VAL_MIN  = 3'd4,
    REG_VAL_MAX  = 3'd5,
    REG_COL_LIM  = 3'd6,
    REG_INVERT   = 3'd7
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_DIV  = 2'd1,
    ST_EMIT = 2'd2
  } state_t;

  typedef struct packed {
    logic [CH_W-1:0] hue;
    logic [CH_W-1:0] sat;
    logic [CH_W-1:0] val;
    logic            row_end;
    logic            frame_end;
  } pix_t;

  typedef struct packed {
    logic accept;
    logic div_start;
    logic load_cent;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic div_done;
    logic div_busy;
  } sts_t;

endpackage

// ----- rtl/core/hcmc_if.sv -----
interface hcmc_in_if;
  logic                      valid;
  logic                      ready;
  logic [hcmc_pkg::CH_W-1:0] hue;
  logic [hcmc_pkg::CH_W-1:0] sat;
  logic [hcmc_pkg::CH_W-1:0] val;
  logic                      row_end;
  logic                      frame_end;

  modport source (output valid, hue, sat, val, row_end, frame_end, input ready);
  modport sink   (input valid, hue, sat, val, row_end, frame_end, output ready);
endinterface

interface hcmc_out_if;
  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic [hcmc_pkg::CH_W-1:0]  mask_value;
  logic                       in_window;
  logic [hcmc_pkg::CEN_W-1:0] centroid_row;
  logic [hcmc_pkg::CEN_W-1:0] centroid_col;
  logic [hcmc_pkg::CNT_W-1:0] match_count;
  logic                       last;

  modport source (output valid, kind, mask_value, in_window, centroid_row, centroid_col,
                  match_count, last, input ready);
  modport sink   (input valid, kind, mask_value, in_window, centroid_row, centroid_col,
                  match_count, last, output ready);
endinterface

// ----- rtl/core/hsv_color_mask_centroid.sv -----
// Mask results are registered: each pixel's result is loaded into the output register when its request is accepted.
// Throughput: one pixel per cycle while the result side keeps up, within a frame.
// Frame end: a restoring divider (one quotient bit per cycle) forms the centroid;
//   the centroid result is loaded into the output register once the divide is done
//   and the output is free, and no pixel is taken until it is loaded.
// Reset (rst_n low, synchronous): registers to defaults, position, sums and count to 0.
module hsv_color_mask_centroid (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [hcmc_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [hcmc_pkg::CFG_DAT_W-1:0] cfg_wdata,
  hcmc_in_if.sink                        in_pix,
  hcmc_out_if.source                     out_pix
);

  hcmc_pkg::cmd_t             cmd;
  hcmc_pkg::sts_t             sts;
  hcmc_pkg::pix_t             pix;
  logic                       in_ready;
  logic [hcmc_pkg::SUM_W-1:0] dvd_row, dvd_col, quo_row, quo_col;
  logic [hcmc_pkg::CNT_W-1:0] dvs;
  logic                       div_busy, div_done;

  assign pix.hue       = in_pix.hue;
  assign pix.sat       = in_pix.sat;
  assign pix.val       = in_pix.val;
  assign pix.row_end   = in_pix.row_end;
  assign pix.frame_end = in_pix.frame_end;
  assign in_pix.ready  = in_ready;

  hcmc_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_pix.valid),
    .in_frame_end (in_pix.frame_end),
    .sts          (sts),
    .in_ready     (in_ready),
    .cmd          (cmd)
  );

  hcmc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .dvd_a (dvd_row),
    .dvd_b (dvd_col),
    .dvs   (dvs),
    .quo_a (quo_row),
    .quo_b (quo_col),
    .busy  (div_busy),
    .done  (div_done)
  );

  hcmc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .pix       (pix),
    .cmd       (cmd),
    .div_busy  (div_busy),
    .div_done  (div_done),
    .quo_row   (quo_row),
    .quo_col   (quo_col),
    .dvd_row   (dvd_row),
    .dvd_col   (dvd_col),
    .dvs       (dvs),
    .sts       (sts),
    .out_pix   (out_pix)
  );

`ifndef SYNTHESIS
  a_frame_end_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    in_pix.valid && in_pix.ready && in_pix.frame_end |=> !in_pix.ready)
    else $error("pixel taken right after frame end");

  a_busy_no_ready: assert property (@(posedge clk) disable iff (!rst_n)
    div_busy |-> !in_pix.ready)
    else $error("pixel request accepted while centroid divide runs");

  a_centroid_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_pix.valid && (out_pix.kind == hcmc_pkg::KIND_CENTROID) |->
      out_pix.last && (out_pix.mask_value == hcmc_pkg::MASK_OFF) && !out_pix.in_window)
    else $error("centroid result malformed");
`endif

endmodule

// ----- rtl/core/hcmc_div.sv -----
module hcmc_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [hcmc_pkg::SUM_W-1:0]  dvd_a,
  input  logic [hcmc_pkg::SUM_W-1:0]  dvd_b,
  input  logic [hcmc_pkg::CNT_W-1:0]  dvs,
  output logic [hcmc_pkg::SUM_W-1:0]  quo_a,
  output logic [hcmc_pkg::SUM_W-1:0]  quo_b,
  output logic                        busy,
  output logic                        done
);

  logic [hcmc_pkg::SUM_W-1:0]  a_r, a_nxt, b_r, b_nxt;
  logic [hcmc_pkg::CNT_W-1:0]  ra_r, ra_nxt, rb_r, rb_nxt, dvs_r;
  logic [hcmc_pkg::STEP_W-1:0] step_r, step_nxt;
  logic                        busy_r, busy_nxt, done_r, done_nxt;
  logic [hcmc_pkg::CNT_W:0]    ta, tb, da, db;
  logic                        qa, qb;

  // restoring, one quotient bit per cycle for both dividends
  always_comb begin
    ta = {ra_r, a_r[hcmc_pkg::SUM_W-1]};
    tb = {rb_r, b_r[hcmc_pkg::SUM_W-1]};
    da = ta - {1'b0, dvs_r};
    db = tb - {1'b0, dvs_r};
    qa = (ta >= {1'b0, dvs_r});
    qb = (tb >= {1'b0, dvs_r});
    a_nxt    = a_r;
    b_nxt    = b_r;
    ra_nxt   = ra_r;
    rb_nxt   = rb_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      a_nxt    = dvd_a;
      b_nxt    = dvd_b;
      ra_nxt   = '0;
      rb_nxt   = '0;
      step_nxt = hcmc_pkg::STEP_W'(hcmc_pkg::SUM_W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      a_nxt  = {a_r[hcmc_pkg::SUM_W-2:0], qa};
      b_nxt  = {b_r[hcmc_pkg::SUM_W-2:0], qb};
      ra_nxt = qa ? da[hcmc_pkg::CNT_W-1:0] : ta[hcmc_pkg::CNT_W-1:0];
      rb_nxt = qb ? db[hcmc_pkg::CNT_W-1:0] : tb[hcmc_pkg::CNT_W-1:0];
      step_nxt = step_r - 1'b1;
      if (step_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    a_r  <= a_nxt;
    b_r  <= b_nxt;
    ra_r <= ra_nxt;
    rb_r <= rb_nxt;
    if (start) begin
      dvs_r <= dvs;
    end
  end

  assign quo_a = a_r;
  assign quo_b = b_r;
  assign busy  = busy_r;
  assign done  = done_r;

endmodule

// ----- rtl/core/hcmc_ctrl.sv -----
module hcmc_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_frame_end,
  input  hcmc_pkg::sts_t sts,
  output logic           in_ready,
  output hcmc_pkg::cmd_t cmd
);

  hcmc_pkg::state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      hcmc_pkg::ST_IDLE: begin
        if (in_valid && sts.out_free && in_frame_end) begin
          state_nxt = hcmc_pkg::ST_DIV;
        end
      end
      hcmc_pkg::ST_DIV: begin
        if (sts.div_done) begin
          state_nxt = hcmc_pkg::ST_EMIT;
        end
      end
      hcmc_pkg::ST_EMIT: begin
        if (sts.out_free) begin
          state_nxt = hcmc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = hcmc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    cmd.accept    = 1'b0;
    cmd.div_start = 1'b0;
    cmd.load_cent = 1'b0;
    case (state_r)
      hcmc_pkg::ST_IDLE: begin
        in_ready      = sts.out_free;
        cmd.accept    = in_valid && sts.out_free;
        cmd.div_start = in_valid && sts.out_free && in_frame_end;
      end
      hcmc_pkg::ST_EMIT: begin
        cmd.load_cent = sts.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hcmc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/core/hcmc_dp.sv -----
module hcmc_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [hcmc_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [hcmc_pkg::CFG_DAT_W-1:0] cfg_wdata,
  input  hcmc_pkg::pix_t                 pix,
  input  hcmc_pkg::cmd_t                 cmd,
  input  logic                           div_busy,
  input  logic                           div_done,
  input  logic [hcmc_pkg::SUM_W-1:0]     quo_row,
  input  logic [hcmc_pkg::SUM_W-1:0]     quo_col,
  output logic [hcmc_pkg::SUM_W-1:0]     dvd_row,
  output logic [hcmc_pkg::SUM_W-1:0]     dvd_col,
  output logic [hcmc_pkg::CNT_W-1:0]     dvs,
  output hcmc_pkg::sts_t                 sts,
  hcmc_out_if.source                     out_pix
);

  logic [hcmc_pkg::CH_W-1:0]  hue_min_r, hue_max_r, sat_min_r, sat_max_r;
  logic [hcmc_pkg::CH_W-1:0]  val_min_r, val_max_r;
  logic [hcmc_pkg::LIM_W-1:0] col_lim_r;
  logic                       invert_r;

  logic [hcmc_pkg::ROW_W-1:0] row_pos_r, row_pos_nxt;
  logic [hcmc_pkg::COL_W-1:0] col_pos_r, col_pos_nxt;
  logic [hcmc_pkg::SUM_W-1:0] row_sum_r, row_sum_nxt, col_sum_r, col_sum_nxt;
  logic [hcmc_pkg::CNT_W-1:0] cnt_r, cnt_nxt, cnt_lat_r;
  logic [hcmc_pkg::SUM_W-1:0] row_acc, col_acc;
  logic [hcmc_pkg::CNT_W-1:0] cnt_acc;
  logic [hcmc_pkg::SUM_W:0]   row_add, col_add;
  logic                       match, inwin, hit, on;

  logic                       out_valid_r;
  logic                       kind_r, inwin_r, last_r;
  logic [hcmc_pkg::CH_W-1:0]  mask_r;
  logic [hcmc_pkg::CEN_W-1:0] cen_row_r, cen_col_r;
  logic [hcmc_pkg::CNT_W-1:0] count_r;

  always_comb begin
    match = (pix.hue >= hue_min_r) && (pix.hue <= hue_max_r) &&
            (pix.sat >= sat_min_r) && (pix.sat <= sat_max_r) &&
            (pix.val >= val_min_r) && (pix.val <= val_max_r);
    inwin = hcmc_pkg::CMP_W'(col_pos_r) <= hcmc_pkg::CMP_W'(col_lim_r);
    hit   = inwin && match && (cnt_r != hcmc_pkg::CNT_MAX);
    on    = invert_r ? !match : match;

    row_add = {1'b0, row_sum_r} + (hcmc_pkg::SUM_W + 1)'(row_pos_r);
    col_add = {1'b0, col_sum_r} + (hcmc_pkg::SUM_W + 1)'(col_pos_r);
    row_acc = row_sum_r;
    col_acc = col_sum_r;
    cnt_acc = cnt_r;
    if (hit) begin
      row_acc = (row_add > (hcmc_pkg::SUM_W + 1)'(hcmc_pkg::SUM_MAX)) ?
                hcmc_pkg::SUM_MAX : row_add[hcmc_pkg::SUM_W-1:0];
      col_acc = (col_add > (hcmc_pkg::SUM_W + 1)'(hcmc_pkg::SUM_MAX)) ?
                hcmc_pkg::SUM_MAX : col_add[hcmc_pkg::SUM_W-1:0];
      cnt_acc = cnt_r + 1'b1;
    end

    row_pos_nxt = row_pos_r;
    col_pos_nxt = col_pos_r;
    row_sum_nxt = row_sum_r;
    col_sum_nxt = col_sum_r;
    cnt_nxt     = cnt_r;
    if (cmd.accept) begin
      if (pix.frame_end) begin
        row_pos_nxt = '0;
        col_pos_nxt = '0;
        row_sum_nxt = '0;
        col_sum_nxt = '0;
        cnt_nxt     = '0;
      end else begin
        row_sum_nxt = row_acc;
        col_sum_nxt = col_acc;
        cnt_nxt     = cnt_acc;
        if (pix.row_end) begin
          col_pos_nxt = '0;
          if (row_pos_r != hcmc_pkg::ROW_LAST) begin
            row_pos_nxt = row_pos_r + 1'b1;
          end
        end else if (col_pos_r != hcmc_pkg::COL_LAST) begin
          col_pos_nxt = col_pos_r + 1'b1;
        end
      end
    end
  end

  assign dvd_row = row_acc;
  assign dvd_col = col_acc;
  assign dvs     = cnt_acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hue_min_r <= 8'd106;
      hue_max_r <= 8'd111;
      sat_min_r <= 8'd181;
      sat_max_r <= 8'd199;
      val_min_r <= 8'd156;
      val_max_r <= 8'd175;
      col_lim_r <= 10'd1023;
      invert_r  <= 1'b0;
    end else if (cfg_we) begin
      case (hcmc_pkg::cfg_idx_t'(cfg_idx))
        hcmc_pkg::REG_HUE_MIN: hue_min_r <= cfg_wdata[hcmc_pkg::CH_W-1:0];
        hcmc_pkg::REG_HUE_MAX: hue_max_r <= cfg_wdata[hcmc_pkg::CH_W-1:0];
        hcmc_pkg::REG_SAT_MIN: sat_min_r <= cfg_wdata[hcmc_pkg::CH_W-1:0];
        hcmc_pkg::REG_SAT_MAX: sat_max_r <= cfg_wdata[hcmc_pkg::CH_W-1:0];
        hcmc_pkg::REG_VAL_MIN: val_min_r <= cfg_wdata[hcmc_pkg::CH_W-1:0];
        hcmc_pkg::REG_VAL_MAX: val_max_r <= cfg_wdata[hcmc_pkg::CH_W-1:0];
        hcmc_pkg::REG_COL_LIM: col_lim_r <= cfg_wdata[hcmc_pkg::LIM_W-1:0];
        hcmc_pkg::REG_INVERT:  invert_r  <= cfg_wdata[0];
        default: invert_r <= invert_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_pos_r <= '0;
      col_pos_r <= '0;
      row_sum_r <= '0;
      col_sum_r <= '0;
      cnt_r     <= '0;
    end else begin
      row_pos_r <= row_pos_nxt;
      col_pos_r <= col_pos_nxt;
      row_sum_r <= row_sum_nxt;
      col_sum_r <= col_sum_nxt;
      cnt_r     <= cnt_nxt;
    end
    if (cmd.div_start) begin
      cnt_lat_r <= cnt_acc;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.accept || cmd.load_cent) begin
      out_valid_r <= 1'b1;
    end else if (out_pix.ready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.accept) begin
      kind_r    <= hcmc_pkg::KIND_MASK;
      mask_r    <= (inwin && on) ? hcmc_pkg::MASK_ON : hcmc_pkg::MASK_OFF;
      inwin_r   <= inwin;
      cen_row_r <= '0;
      cen_col_r <= '0;
      count_r   <= '0;
      last_r    <= !pix.frame_end;
    end else if (cmd.load_cent) begin
      kind_r    <= hcmc_pkg::KIND_CENTROID;
      mask_r    <= hcmc_pkg::MASK_OFF;
      inwin_r   <= 1'b0;
      cen_row_r <= (cnt_lat_r == '0) ? '0 : quo_row[hcmc_pkg::CEN_W-1:0];
      cen_col_r <= (cnt_lat_r == '0) ? '0 : quo_col[hcmc_pkg::CEN_W-1:0];
      count_r   <= cnt_lat_r;
      last_r    <= 1'b1;
    end
  end

  assign sts.out_free = !out_valid_r || out_pix.ready;
  assign sts.div_done = div_done;
  assign sts.div_busy = div_busy;

  assign out_pix.valid        = out_valid_r;
  assign out_pix.kind         = kind_r;
  assign out_pix.mask_value   = mask_r;
  assign out_pix.in_window    = inwin_r;
  assign out_pix.centroid_row = cen_row_r;
  assign out_pix.centroid_col = cen_col_r;
  assign out_pix.match_count  = count_r;
  assign out_pix.last         = last_r;

endmodule

// ----- tb/hsv_color_mask_centroid_tb.sv -----
`timescale 1ns / 100ps

module hsv_color_mask_centroid_tb;
  import hcmc_pkg::*;

  localparam int SETTLE_CYCLES = 40;
  localparam int DRAIN_LIMIT = 20000;

  typedef enum logic [1:0] {
    OP_PIXEL,
    OP_WRITE,
    OP_SETTLE
  } stream_op_t;

  typedef struct packed {
    stream_op_t             op;
    pix_t                   pix;
    cfg_idx_t               idx;
    logic [CFG_DAT_W-1:0]   data;
  } stream_cmd_t;

  typedef struct packed {
    logic             kind;
    logic [CH_W-1:0]  mask_value;
    logic             in_window;
    logic [CEN_W-1:0] centroid_row;
    logic [CEN_W-1:0] centroid_col;
    logic [CNT_W-1:0] match_count;
    logic             last;
  } pix_result_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_DAT_W-1:0] cfg_wdata;

  hcmc_in_if  in_pix ();
  hcmc_out_if out_pix ();

  hsv_color_mask_centroid dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_pix    (in_pix),
    .out_pix   (out_pix)
  );

  stream_cmd_t pixel_q[$];
  pix_result_t mask_centroid_q[$];

  // predictor state
  logic [CFG_DAT_W-1:0] cfg_shadow [8];
  logic [ROW_W-1:0]     row_at;
  logic [COL_W-1:0]     col_at;
  logic [SUM_W-1:0]     row_acc;
  logic [SUM_W-1:0]     col_acc;
  logic [CNT_W-1:0]     hits;

  // generator view of the windows
  int gen_lo [3];
  int gen_hi [3];
  int px_queued;

  int gap_left;
  int stall_left;
  int settle_left;
  int send_calm;
  int recv_calm;
  int mismatches;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = REG_HUE_MIN;
    cfg_wdata = '0;
    in_pix.valid = 1'b0;
    in_pix.hue = '0;
    in_pix.sat = '0;
    in_pix.val = '0;
    in_pix.row_end = 1'b0;
    in_pix.frame_end = 1'b0;
    out_pix.ready = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #40_000_000;
    $display("hsv_color_mask_centroid_tb NOT OK");
    $finish;
  end

  function automatic int pause_len(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 100);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(12, 40);
  endfunction

  function automatic logic [SUM_W-1:0] sum_sat(logic [SUM_W-1:0] a, logic [COL_W-1:0] b);
    logic [SUM_W:0] s;
    s = a + b;
    return (s > SUM_MAX) ? SUM_MAX : s[SUM_W-1:0];
  endfunction

  task automatic classify_pixel(pix_t p);
    logic        inwin;
    logic        match;
    logic        on;
    pix_result_t r;
    inwin = col_at <= cfg_shadow[REG_COL_LIM];
    match = p.hue >= cfg_shadow[REG_HUE_MIN][CH_W-1:0]
         && p.hue <= cfg_shadow[REG_HUE_MAX][CH_W-1:0]
         && p.sat >= cfg_shadow[REG_SAT_MIN][CH_W-1:0]
         && p.sat <= cfg_shadow[REG_SAT_MAX][CH_W-1:0]
         && p.val >= cfg_shadow[REG_VAL_MIN][CH_W-1:0]
         && p.val <= cfg_shadow[REG_VAL_MAX][CH_W-1:0];
    r = '0;
    r.kind = KIND_MASK;
    r.mask_value = MASK_OFF;
    r.in_window = inwin;
    r.last = !p.frame_end;
    if (inwin) begin
      on = cfg_shadow[REG_INVERT][0] ? !match : match;
      r.mask_value = on ? MASK_ON : MASK_OFF;
      if (match && hits < CNT_MAX) begin
        hits++;
        row_acc = sum_sat(row_acc, row_at);
        col_acc = sum_sat(col_acc, col_at);
      end
    end
    mask_centroid_q.push_back(r);
    if (!p.frame_end) begin
      if (p.row_end) begin
        col_at = '0;
        if (row_at < ROW_LAST) row_at++;
      end else if (col_at < COL_LAST) begin
        col_at++;
      end
    end else begin
      r = '0;
      r.kind = KIND_CENTROID;
      r.last = 1'b1;
      if (hits != 0) begin
        r.centroid_row = CEN_W'(row_acc / hits);
        r.centroid_col = CEN_W'(col_acc / hits);
      end
      r.match_count = hits;
      mask_centroid_q.push_back(r);
      row_at = '0;
      col_at = '0;
      row_acc = '0;
      col_acc = '0;
      hits = '0;
    end
  endtask

  always @(posedge clk) begin : drive
    logic        next_valid;
    logic        next_we;
    stream_cmd_t head;
    if (!rst_n) begin
      in_pix.valid <= 1'b0;
      cfg_we <= 1'b0;
    end else begin
      next_valid = in_pix.valid;
      next_we = 1'b0;
      if (in_pix.valid && in_pix.ready) begin
        head = pixel_q.pop_front();
        classify_pixel(head.pix);
        next_valid = 1'b0;
        gap_left = pause_len(send_calm);
      end
      if (!next_valid && pixel_q.size() != 0) begin
        head = pixel_q[0];
        case (head.op)
          OP_PIXEL: begin
            if (gap_left != 0) begin
              gap_left--;
            end else begin
              next_valid = 1'b1;
              in_pix.hue <= head.pix.hue;
              in_pix.sat <= head.pix.sat;
              in_pix.val <= head.pix.val;
              in_pix.row_end <= head.pix.row_end;
              in_pix.frame_end <= head.pix.frame_end;
            end
          end
          OP_WRITE: begin
            next_we = 1'b1;
            cfg_idx <= head.idx;
            cfg_wdata <= head.data;
            cfg_shadow[head.idx] = head.data;
            pixel_q.delete(0);
          end
          default: begin
            // hold off until the block has drained
            if (mask_centroid_q.size() != 0) begin
              settle_left = SETTLE_CYCLES;
            end else if (settle_left != 0) begin
              settle_left--;
            end else begin
              settle_left = SETTLE_CYCLES;
              pixel_q.delete(0);
            end
          end
        endcase
      end
      in_pix.valid <= next_valid;
      cfg_we <= next_we;
    end
  end

  always @(posedge clk) begin : watch
    pix_result_t got;
    pix_result_t want;
    if (!rst_n) begin
      out_pix.ready <= 1'b0;
    end else begin
      if (out_pix.valid && out_pix.ready) begin
        got.kind = out_pix.kind;
        got.mask_value = out_pix.mask_value;
        got.in_window = out_pix.in_window;
        got.centroid_row = out_pix.centroid_row;
        got.centroid_col = out_pix.centroid_col;
        got.match_count = out_pix.match_count;
        got.last = out_pix.last;
        if (mask_centroid_q.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result: kind=%0d mask=%0d win=%0d row=%0d col=%0d cnt=%0d last=%0d",
                     got.kind, got.mask_value, got.in_window, got.centroid_row,
                     got.centroid_col, got.match_count, got.last);
          mismatches++;
        end else begin
          want = mask_centroid_q.pop_front();
          if (got !== want) begin
            if (mismatches < 10) begin
              $display("mismatch exp: kind=%0d mask=%0d win=%0d row=%0d col=%0d cnt=%0d last=%0d",
                       want.kind, want.mask_value, want.in_window, want.centroid_row,
                       want.centroid_col, want.match_count, want.last);
              $display("         got: kind=%0d mask=%0d win=%0d row=%0d col=%0d cnt=%0d last=%0d",
                       got.kind, got.mask_value, got.in_window, got.centroid_row,
                       got.centroid_col, got.match_count, got.last);
            end
            mismatches++;
          end
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        out_pix.ready <= 1'b0;
      end else begin
        out_pix.ready <= 1'b1;
        stall_left = pause_len(recv_calm);
      end
    end
  end

  task automatic queue_pixel(logic [CH_W-1:0] h, logic [CH_W-1:0] s, logic [CH_W-1:0] v,
                             logic re, logic fe);
    stream_cmd_t c;
    c = '0;
    c.op = OP_PIXEL;
    c.pix.hue = h;
    c.pix.sat = s;
    c.pix.val = v;
    c.pix.row_end = re;
    c.pix.frame_end = fe;
    pixel_q.push_back(c);
    px_queued++;
  endtask

  task automatic queue_write(cfg_idx_t idx, int data);
    stream_cmd_t c;
    c = '0;
    c.op = OP_WRITE;
    c.idx = idx;
    c.data = CFG_DAT_W'(data);
    pixel_q.push_back(c);
  endtask

  task automatic queue_settle();
    stream_cmd_t c;
    c = '0;
    c.op = OP_SETTLE;
    pixel_q.push_back(c);
  endtask

  task automatic queue_windows(int hl, int hh, int sl, int sh, int vl, int vh,
                               int lim, int inv);
    queue_settle();
    queue_write(REG_HUE_MIN, hl);
    queue_write(REG_HUE_MAX, hh);
    queue_write(REG_SAT_MIN, sl);
    queue_write(REG_SAT_MAX, sh);
    queue_write(REG_VAL_MIN, vl);
    queue_write(REG_VAL_MAX, vh);
    queue_write(REG_COL_LIM, lim);
    queue_write(REG_INVERT, inv);
    gen_lo = '{hl, sl, vl};
    gen_hi = '{hh, sh, vh};
  endtask

  task automatic queue_random_windows(int lim, int inv);
    int lo [3];
    int hi [3];
    int t;
    for (int ch = 0; ch < 3; ch++) begin
      lo[ch] = $urandom_range(0, 255);
      hi[ch] = lo[ch] + $urandom_range(0, 80);
      if (hi[ch] > 255) hi[ch] = 255;
      if ($urandom_range(0, 9) == 0) begin
        t = lo[ch];
        lo[ch] = hi[ch] + 1;
        hi[ch] = t;
        if (lo[ch] > 255) lo[ch] = 255;
      end
    end
    queue_windows(lo[0], hi[0], lo[1], hi[1], lo[2], hi[2], lim, inv);
  endtask

  function automatic logic [CH_W-1:0] pick_chan(int ch);
    int lo;
    int hi;
    int r;
    lo = gen_lo[ch];
    hi = gen_hi[ch];
    r = $urandom_range(0, 9);
    if (r < 5 && lo <= hi) return CH_W'($urandom_range(lo, hi));
    if (r < 7) begin
      case ($urandom_range(0, 3))
        0: return CH_W'(lo);
        1: return CH_W'(hi);
        2: return CH_W'(lo - 1);
        default: return CH_W'(hi + 1);
      endcase
    end
    return CH_W'($urandom_range(0, 255));
  endfunction

  task automatic queue_random_pixel(logic re, logic fe);
    queue_pixel(pick_chan(0), pick_chan(1), pick_chan(2), re, fe);
  endtask

  // raster frame with occasional stray row/frame markers
  task automatic queue_frame(int w, int h);
    logic re;
    logic fe;
    for (int r = 0; r < h; r++) begin
      for (int c = 0; c < w; c++) begin
        re = (c == w - 1);
        fe = (r == h - 1) && (c == w - 1);
        if ($urandom_range(0, 39) == 0) begin
          re = $urandom_range(0, 1);
          fe = $urandom_range(0, 1);
        end
        queue_random_pixel(re, fe);
      end
    end
  endtask

  initial begin : stimulus
    int goal;
    int waited;
    cfg_shadow[REG_HUE_MIN] = 106;
    cfg_shadow[REG_HUE_MAX] = 111;
    cfg_shadow[REG_SAT_MIN] = 181;
    cfg_shadow[REG_SAT_MAX] = 199;
    cfg_shadow[REG_VAL_MIN] = 156;
    cfg_shadow[REG_VAL_MAX] = 175;
    cfg_shadow[REG_COL_LIM] = 1023;
    cfg_shadow[REG_INVERT] = 0;
    row_at = '0;
    col_at = '0;
    row_acc = '0;
    col_acc = '0;
    hits = '0;
    gen_lo = '{106, 181, 156};
    gen_hi = '{111, 199, 175};
    px_queued = 0;
    gap_left = 0;
    stall_left = 0;
    settle_left = SETTLE_CYCLES;
    send_calm = 0;
    recv_calm = 0;
    mismatches = 0;

    // window edges under reset settings
    queue_pixel(106, 181, 156, 1'b0, 1'b0);
    queue_pixel(111, 199, 175, 1'b0, 1'b0);
    queue_pixel(105, 190, 160, 1'b0, 1'b0);
    queue_pixel(112, 190, 160, 1'b1, 1'b0);
    queue_pixel(108, 180, 160, 1'b0, 1'b0);
    queue_pixel(108, 200, 160, 1'b0, 1'b0);
    queue_pixel(108, 190, 155, 1'b0, 1'b0);
    queue_pixel(108, 190, 176, 1'b1, 1'b0);
    queue_pixel(0, 0, 0, 1'b0, 1'b0);
    queue_pixel(255, 255, 255, 1'b0, 1'b0);
    queue_pixel(109, 190, 170, 1'b1, 1'b1);
    // frame with no match, then a one-pixel frame that matches
    queue_pixel(0, 0, 0, 1'b0, 1'b0);
    queue_pixel(255, 255, 255, 1'b0, 1'b1);
    queue_pixel(110, 190, 170, 1'b0, 1'b1);
    // full window, inverted, narrow column limit
    queue_windows(0, 255, 0, 255, 0, 255, 1, 1);
    queue_pixel(0, 0, 0, 1'b0, 1'b0);
    queue_pixel(255, 255, 255, 1'b0, 1'b0);
    queue_pixel(128, 128, 128, 1'b0, 1'b0);
    queue_pixel(7, 7, 7, 1'b0, 1'b1);

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: queue_windows(0, 255, 0, 255, 0, 255, 1023, 0);
        1: queue_windows(255, 0, 0, 255, 0, 255, 5, 1);
        2: queue_random_windows($urandom_range(0, 12), 0);
        3: queue_random_windows(0, 1);
        4: queue_random_windows($urandom_range(0, 1023), $urandom_range(0, 1));
        default: queue_windows(106, 111, 181, 199, 156, 175, $urandom_range(2, 10), 0);
      endcase
      goal = px_queued + 105;
      while (px_queued < goal) begin
        if ($urandom_range(0, 9) == 0)
          queue_frame($urandom_range(1, 30), 1);
        else
          queue_frame($urandom_range(1, 12), $urandom_range(1, 6));
      end
    end

    while (pixel_q.size() != 0 || in_pix.valid) @(posedge clk);
    waited = 0;
    while (mask_centroid_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    mismatches += mask_centroid_q.size();
    if (mismatches == 0)
      $display("hsv_color_mask_centroid_tb OK");
    else
      $display("hsv_color_mask_centroid_tb NOT OK");
    $finish;
  end

endmodule
